// ----- rtl/rcce_pkg.sv -----
// rcce_pkg: shared types and constants of the residue class coverage engine
// no dependencies; used by the top level and the checker
package rcce_pkg;

	// store geometry
	localparam int PERIOD_MAX = 65536;
	localparam int ADDR_W     = $clog2(PERIOD_MAX);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int POS_W      = LEN_W + 1;
	localparam int CNT_W      = 13;
	localparam int MARKS_MAX  = 4096;

	// config register map
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] REG_PERIOD = PADDR_W'(0);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_MARK   = 2'd1,
		OP_UNMARK = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] residue;
		logic [16:0] modulus;
	} in_item_t;

	typedef struct packed {
		logic [15:0] best_class;
		logic [16:0] best_gain;
		logic [16:0] uncovered_total;
	} out_item_t;

endpackage

// ----- rtl/residue_class_coverage_engine.sv -----
// residue_class_coverage_engine: top level with coverage store and sequencer
// depends on rcce_pkg and rcce_ram
//
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_item  (rcce_pkg::in_item_t)
// out       output     out_valid / out_stall  out_item (rcce_pkg::out_item_t)
// cfg       input      apb write/read         period at byte address 0
//
// from acceptance to the result: mark and unmark read each touched position and
// then update it; a query reads every ring position, class by class; clear
// sweeps the whole store; an item that touches no position goes straight to the
// result.
// after reset the same sweep zeroes the store; in_stall stays high.
// one item is worked at a time and the input reopens as the result
// is loaded; the result register lets the next item start while out_stall holds
// the previous result, and a finished item waits while that result is stalled.
module residue_class_coverage_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rcce_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rcce_pkg::out_item_t               out_item,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rcce_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	rcce_pkg::state_t state_q, state_d;

	logic [rcce_pkg::LEN_W-1:0] period_q;
	logic [rcce_pkg::LEN_W-1:0] len;
	logic [rcce_pkg::POS_W-1:0] pos_q, pos_next;
	logic [rcce_pkg::LEN_W-1:0] step_q;
	logic [rcce_pkg::LEN_W-1:0] class_q, class_next, classes_q;
	logic [rcce_pkg::LEN_W-1:0] cnt_q, cnt_inc;
	logic [rcce_pkg::LEN_W-1:0] best_gain_q;
	logic [15:0]                best_class_q;
	logic [rcce_pkg::LEN_W-1:0] unc_q;
	rcce_pkg::op_t              op_q;
	logic                       item_q;
	logic                       out_valid_q;
	rcce_pkg::out_item_t        out_q;

	logic                        accept;
	logic                        walk_end;
	logic                        cnt_zero;
	logic                        mem_we;
	logic [rcce_pkg::CNT_W-1:0]  mem_wdata;
	logic [rcce_pkg::CNT_W-1:0]  mem_rdata;
	logic                        out_free;
	logic                        acc_skip;

	// ring length is period clamped to the store size
	assign len = (period_q > rcce_pkg::LEN_W'(rcce_pkg::PERIOD_MAX))
		? rcce_pkg::LEN_W'(rcce_pkg::PERIOD_MAX) : period_q;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign pos_next = pos_q + {1'b0, step_q};
	assign walk_end = pos_next >= {1'b0, len};
	assign cnt_zero = (mem_rdata == '0);
	assign cnt_inc  = cnt_q + (cnt_zero ? rcce_pkg::LEN_W'(1) : '0);
	assign class_next = class_q + rcce_pkg::LEN_W'(1);

	// items that need no store access
	always_comb begin
		if (rcce_pkg::op_t'(in_item.op) == rcce_pkg::OP_QUERY) begin
			acc_skip = (in_item.modulus == '0) || (len == '0);
		end else begin
			acc_skip = (in_item.modulus == '0) ||
				({1'b0, in_item.residue} >= len);
		end
	end

	// coverage store
	rcce_ram #(
		.WIDTH (rcce_pkg::CNT_W),
		.DEPTH (rcce_pkg::PERIOD_MAX)
	) u_cov (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pos_q[rcce_pkg::ADDR_W-1:0]),
		.wdata (mem_wdata),
		.raddr (pos_q[rcce_pkg::ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcce_pkg::ST_SWEEP: begin
				if (pos_q[rcce_pkg::ADDR_W-1:0] == '1) begin
					state_d = item_q ? rcce_pkg::ST_DONE : rcce_pkg::ST_IDLE;
				end
			end
			rcce_pkg::ST_IDLE: begin
				if (accept) begin
					if (rcce_pkg::op_t'(in_item.op) == rcce_pkg::OP_CLEAR) begin
						state_d = rcce_pkg::ST_SWEEP;
					end else if (acc_skip) begin
						state_d = rcce_pkg::ST_DONE;
					end else begin
						state_d = rcce_pkg::ST_READ;
					end
				end
			end
			rcce_pkg::ST_READ: begin
				state_d = rcce_pkg::ST_UPDATE;
			end
			rcce_pkg::ST_UPDATE: begin
				if (walk_end && (op_q != rcce_pkg::OP_QUERY || class_next == classes_q)) begin
					state_d = rcce_pkg::ST_DONE;
				end else begin
					state_d = rcce_pkg::ST_READ;
				end
			end
			rcce_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rcce_pkg::ST_IDLE;
				end
			end
			default: state_d = rcce_pkg::ST_IDLE;
		endcase
	end

	// state outputs: input stall and store write
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			rcce_pkg::ST_IDLE:  in_stall = 1'b0;
			rcce_pkg::ST_SWEEP: mem_we = 1'b1;
			rcce_pkg::ST_UPDATE: begin
				if (op_q == rcce_pkg::OP_MARK &&
					mem_rdata < rcce_pkg::CNT_W'(rcce_pkg::MARKS_MAX)) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata + rcce_pkg::CNT_W'(1);
				end else if (op_q == rcce_pkg::OP_UNMARK && !cnt_zero) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata - rcce_pkg::CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcce_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// walk position, counters and uncovered total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			item_q       <= 1'b0;
			unc_q        <= rcce_pkg::LEN_W'(rcce_pkg::PERIOD_MAX);
			op_q         <= rcce_pkg::OP_CLEAR;
			step_q       <= '0;
			class_q      <= '0;
			classes_q    <= '0;
			cnt_q        <= '0;
			best_gain_q  <= '0;
			best_class_q <= '0;
		end else begin
			case (state_q)
				rcce_pkg::ST_IDLE: begin
					if (accept) begin
						op_q         <= rcce_pkg::op_t'(in_item.op);
						item_q       <= 1'b1;
						step_q       <= in_item.modulus;
						class_q      <= '0;
						cnt_q        <= '0;
						best_gain_q  <= '0;
						best_class_q <= '0;
						classes_q    <= (in_item.modulus < len) ? in_item.modulus : len;
						if (rcce_pkg::op_t'(in_item.op) == rcce_pkg::OP_MARK ||
							rcce_pkg::op_t'(in_item.op) == rcce_pkg::OP_UNMARK) begin
							pos_q <= rcce_pkg::POS_W'(in_item.residue);
						end else begin
							pos_q <= '0;
						end
					end
				end
				rcce_pkg::ST_SWEEP: begin
					pos_q <= pos_q + rcce_pkg::POS_W'(1);
					if (pos_q[rcce_pkg::ADDR_W-1:0] == '1 && item_q) begin
						unc_q <= len;
					end
				end
				rcce_pkg::ST_UPDATE: begin
					if (op_q == rcce_pkg::OP_QUERY) begin
						if (walk_end) begin
							// class finished: keep the first largest score
							if (class_q == '0 || cnt_inc > best_gain_q) begin
								best_gain_q  <= cnt_inc;
								best_class_q <= class_q[15:0];
							end
							class_q <= class_next;
							pos_q   <= rcce_pkg::POS_W'(class_next);
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_inc;
							pos_q <= pos_next;
						end
					end else begin
						pos_q <= pos_next;
						if (op_q == rcce_pkg::OP_MARK && cnt_zero && unc_q != '0) begin
							unc_q <= unc_q - rcce_pkg::LEN_W'(1);
						end else if (op_q == rcce_pkg::OP_UNMARK &&
							mem_rdata == rcce_pkg::CNT_W'(1) && unc_q != '1) begin
							unc_q <= unc_q + rcce_pkg::LEN_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rcce_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcce_pkg::ST_DONE && out_free) begin
			out_q.best_class      <= best_class_q;
			out_q.best_gain       <= best_gain_q;
			out_q.uncovered_total <= unc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= rcce_pkg::LEN_W'(rcce_pkg::PERIOD_MAX);
		end else if (psel && penable && pwrite && pready && paddr == rcce_pkg::REG_PERIOD) begin
			period_q <= pwdata[rcce_pkg::LEN_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == rcce_pkg::REG_PERIOD) ? 32'(period_q) : '0;

endmodule

// ----- rtl/rcce_ram.sv -----
// rcce_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module rcce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rcce_checker.sv -----
// rcce_checker: port-level assertions for the residue class coverage engine
// depends on rcce_pkg; bound to residue_class_coverage_engine
module rcce_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input rcce_pkg::out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// one item at a time: an accepted item stalls the input next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an item");

	// a zero score always comes with class zero
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.best_gain == '0 |-> out_item.best_class == '0)
		else $error("nonzero class with zero score");

	// the input is stalled as reset is released and the store clear begins
	a_reset_sweep: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall)
		else $error("item taken during reset sweep");

endmodule

bind residue_class_coverage_engine rcce_checker u_rcce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
